### src/eba_pkg.sv
package eba_pkg;

    // Operation codes of the arithmetic and flag unit
    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_ADC     = 4'd1,
        OP_SUB     = 4'd2,
        OP_SBB     = 4'd3,
        OP_CMP     = 4'd4,
        OP_ADD_KC  = 4'd5,
        OP_SUB_KC  = 4'd6,
        OP_DAA     = 4'd7,
        OP_CMA     = 4'd8,
        OP_STC     = 4'd9,
        OP_CMC     = 4'd10
    } op_t;

    // Processor status flags
    typedef struct packed {
        logic carry;
        logic aux;
        logic zero;
        logic parity;
        logic sign;
    } flags_t;

    // Decimal adjust constants
    localparam logic [8:0] DAA_LOW_ADJ   = 9'h006;
    localparam logic [8:0] DAA_HIGH_ADJ  = 9'h060;
    localparam logic [4:0] DAA_DIGIT_MAX = 5'd9;

endpackage

### src/eight_bit_alu_with_flags.sv
// Eight-bit arithmetic and flag unit, two register stages.
// An accepted word is held in the input register, then in the result register, before it is valid at the output.
// Throughput: one word per cycle while m_ready is high; an input register and a result register form the pipe.
// Reset: aresetn low clears both stage valid bits; payload registers are not reset.
module eight_bit_alu_with_flags (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_operation,
    input  logic [7:0] s_first_operand,
    input  logic [7:0] s_second_operand,
    input  logic       s_carry_in,
    input  logic       s_aux_carry_in,
    input  logic       s_zero_in,
    input  logic       s_parity_in,
    input  logic       s_sign_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_byte,
    output logic       m_carry_out,
    output logic       m_aux_carry_out,
    output logic       m_zero_out,
    output logic       m_parity_out,
    output logic       m_sign_out
);

    logic            in_valid_reg;
    eba_pkg::op_t    op_reg;
    logic [7:0]      a_reg;
    logic [7:0]      b_reg;
    eba_pkg::flags_t flags_in_reg;

    logic            out_valid_reg;
    logic [7:0]      result_reg;
    eba_pkg::flags_t flags_out_reg;

    logic            out_load;
    logic            in_load;
    logic [7:0]      result_next;
    eba_pkg::flags_t flags_next;

    // Advance when the next stage is empty or drained this cycle
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    // Hold the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_load) begin
            op_reg       <= eba_pkg::op_t'(s_operation);
            a_reg        <= s_first_operand;
            b_reg        <= s_second_operand;
            flags_in_reg <= '{carry: s_carry_in, aux: s_aux_carry_in, zero: s_zero_in,
                              parity: s_parity_in, sign: s_sign_in};
        end
    end

    eba_core u_core (
        .op             (op_reg),
        .first_operand  (a_reg),
        .second_operand (b_reg),
        .flags_in       (flags_in_reg),
        .result_byte    (result_next),
        .flags_out      (flags_next)
    );

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            result_reg    <= result_next;
            flags_out_reg <= flags_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_byte   = result_reg;
    assign m_carry_out     = flags_out_reg.carry;
    assign m_aux_carry_out = flags_out_reg.aux;
    assign m_zero_out      = flags_out_reg.zero;
    assign m_parity_out    = flags_out_reg.parity;
    assign m_sign_out      = flags_out_reg.sign;

endmodule

### src/eba_core.sv
module eba_core (
    input  eba_pkg::op_t   op,
    input  logic [7:0]     first_operand,
    input  logic [7:0]     second_operand,
    input  eba_pkg::flags_t flags_in,
    output logic [7:0]     result_byte,
    output eba_pkg::flags_t flags_out
);

    logic       use_carry;
    logic [8:0] add_sum;
    logic [4:0] add_nib;
    logic [8:0] sub_diff;
    logic [4:0] sub_nib;
    logic       daa_low;
    logic [8:0] daa_t1;
    logic       daa_high;
    logic [8:0] daa_t2;

    // Carry enters only for add with carry and subtract with borrow
    assign use_carry = flags_in.carry && (op == eba_pkg::OP_ADC || op == eba_pkg::OP_SBB);

    // Adder and subtractor with nibble carry and borrow
    assign add_sum  = {1'b0, first_operand} + {1'b0, second_operand} + {8'd0, use_carry};
    assign add_nib  = {1'b0, first_operand[3:0]} + {1'b0, second_operand[3:0]}
                      + {4'd0, use_carry};
    assign sub_diff = {1'b0, first_operand} - {1'b0, second_operand} - {8'd0, use_carry};
    assign sub_nib  = {1'b0, first_operand[3:0]} - {1'b0, second_operand[3:0]}
                      - {4'd0, use_carry};

    // Decimal adjust: low digit first, then the high digit on the nine-bit sum
    assign daa_low  = flags_in.aux
                      || ({1'b0, first_operand[3:0]} > eba_pkg::DAA_DIGIT_MAX);
    assign daa_t1   = {1'b0, first_operand} + (daa_low ? eba_pkg::DAA_LOW_ADJ : 9'd0);
    assign daa_high = flags_in.carry || (daa_t1[8:4] > eba_pkg::DAA_DIGIT_MAX);
    assign daa_t2   = daa_t1 + (daa_high ? eba_pkg::DAA_HIGH_ADJ : 9'd0);

    // Select result and flags per operation
    always_comb begin
        logic       set_zps;
        logic [7:0] zps_byte;
        set_zps     = 1'b0;
        zps_byte    = first_operand;
        result_byte = first_operand;
        flags_out   = flags_in;
        unique case (op)
            eba_pkg::OP_ADD, eba_pkg::OP_ADC, eba_pkg::OP_ADD_KC: begin
                result_byte   = add_sum[7:0];
                flags_out.aux = add_nib[4];
                if (op != eba_pkg::OP_ADD_KC) begin
                    flags_out.carry = add_sum[8];
                end
                set_zps  = 1'b1;
                zps_byte = add_sum[7:0];
            end
            eba_pkg::OP_SUB, eba_pkg::OP_SBB, eba_pkg::OP_SUB_KC: begin
                result_byte   = sub_diff[7:0];
                flags_out.aux = sub_nib[4];
                if (op != eba_pkg::OP_SUB_KC) begin
                    flags_out.carry = sub_diff[8];
                end
                set_zps  = 1'b1;
                zps_byte = sub_diff[7:0];
            end
            eba_pkg::OP_CMP: begin
                flags_out.aux   = sub_nib[4];
                flags_out.carry = sub_diff[8];
                set_zps  = 1'b1;
                zps_byte = sub_diff[7:0];
            end
            eba_pkg::OP_DAA: begin
                result_byte = daa_t2[7:0];
                if (daa_high) begin
                    flags_out.carry = 1'b1;
                end
                set_zps  = 1'b1;
                zps_byte = daa_t2[7:0];
            end
            eba_pkg::OP_CMA: begin
                result_byte = ~first_operand;
            end
            eba_pkg::OP_STC: begin
                flags_out.carry = 1'b1;
            end
            eba_pkg::OP_CMC: begin
                flags_out.carry = ~flags_in.carry;
            end
            default: begin
                // unused codes pass everything through
                result_byte = first_operand;
            end
        endcase
        if (set_zps) begin
            flags_out.zero   = (zps_byte == 8'd0);
            flags_out.parity = ~(^zps_byte);
            flags_out.sign   = zps_byte[7];
        end
    end

endmodule

### src/eba_checker.sv
module eba_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_result_byte,
    input logic       m_carry_out,
    input logic       m_aux_carry_out,
    input logic       m_zero_out,
    input logic       m_parity_out,
    input logic       m_sign_out
);

    // Drop the result valid after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_byte) && $stable(m_carry_out)
            && $stable(m_aux_carry_out) && $stable(m_zero_out) && $stable(m_parity_out)
            && $stable(m_sign_out))
        else $error("stalled result changed");

    // Accept input whenever the result stage is empty
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

    // Deliver an accepted word through the input and result registers when the output drains
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready |=> m_valid)
        else $error("accepted word not delivered");

endmodule

bind eight_bit_alu_with_flags eba_checker u_eba_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_byte   (m_result_byte),
    .m_carry_out     (m_carry_out),
    .m_aux_carry_out (m_aux_carry_out),
    .m_zero_out      (m_zero_out),
    .m_parity_out    (m_parity_out),
    .m_sign_out      (m_sign_out)
);
